// ===== rtl/tccw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// shared types and constants of the text console cell writer
// ----------------------------------------------------------------------------
package tccw_pkg;

  // default screen geometry
  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  // field widths
  localparam int POS_W  = 11;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int CELL_W = 16;

  // character codes
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_BLANK = 8'h20;
  localparam logic [7:0] CHR_ERR   = 8'h45;

  // register reset values
  localparam logic [7:0] RST_DEFAULT_ATTR   = 8'd15;
  localparam logic [7:0] RST_ERROR_ATTR     = 8'd116;
  localparam logic [7:0] RST_BACKSPACE_CODE = 8'd8;

  // register indexes (word address)
  localparam logic [1:0] REG_DEFAULT_ATTR   = 2'd0;
  localparam logic [1:0] REG_ERROR_ATTR     = 2'd1;
  localparam logic [1:0] REG_BACKSPACE_CODE = 2'd2;

  // function codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // configuration seen by the engine
  typedef struct packed {
    logic [7:0] default_attr;
    logic [7:0] error_attr;
    logic [7:0] backspace_code;
  } cfg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_CLEAR,
    ST_SCROLL,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/tccw_cell_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_cell_ram
// screen cell memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tccw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tccw_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_cfg_regs
// apb register bank: default attribute, error attribute, backspace code
// ----------------------------------------------------------------------------
module tccw_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tccw_pkg::ADDR_W-1:0] paddr,
  input  logic [tccw_pkg::DATA_W-1:0] pwdata,
  output logic [tccw_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tccw_pkg::cfg_t             cfg
);

  import tccw_pkg::*;

  logic [7:0] default_attr_r, default_attr_nxt;
  logic [7:0] error_attr_r, error_attr_nxt;
  logic [7:0] bs_code_r, bs_code_nxt;
  logic       wr_beat;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register write decode
  always_comb begin
    default_attr_nxt = default_attr_r;
    error_attr_nxt   = error_attr_r;
    bs_code_nxt      = bs_code_r;
    if (wr_beat) begin
      case (reg_idx)
        REG_DEFAULT_ATTR:   default_attr_nxt = pwdata[7:0];
        REG_ERROR_ATTR:     error_attr_nxt   = pwdata[7:0];
        REG_BACKSPACE_CODE: bs_code_nxt      = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= RST_DEFAULT_ATTR;
      error_attr_r   <= RST_ERROR_ATTR;
      bs_code_r      <= RST_BACKSPACE_CODE;
    end else begin
      default_attr_r <= default_attr_nxt;
      error_attr_r   <= error_attr_nxt;
      bs_code_r      <= bs_code_nxt;
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_DEFAULT_ATTR:   prdata = DATA_W'(default_attr_r);
      REG_ERROR_ATTR:     prdata = DATA_W'(error_attr_r);
      REG_BACKSPACE_CODE: prdata = DATA_W'(bs_code_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.default_attr   = default_attr_r;
  assign cfg.error_attr     = error_attr_r;
  assign cfg.backspace_code = bs_code_r;

endmodule

// ===== rtl/tccw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_engine
// sequencer and cursor datapath; one address counter serves the
// clear and scroll sweeps over the cell memory
// ----------------------------------------------------------------------------
module tccw_engine #(
  parameter int COLS = tccw_pkg::DEF_COLS,
  parameter int ROWS = tccw_pkg::DEF_ROWS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tccw_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_func,
  input  logic [7:0]                 in_chr,
  input  logic [7:0]                 in_attr,
  input  logic signed [7:0]          in_col,
  input  logic signed [6:0]          in_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_status,
  output logic [tccw_pkg::POS_W-1:0] out_position,
  output logic [7:0]                 out_read_char,
  output logic [7:0]                 out_read_attr
);

  import tccw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLS);

  localparam logic [AW-1:0]  LAST_CELL    = AW'(CELLS - 1);
  localparam logic [AW-1:0]  LAST_ROW_LIN = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0]  COLS_A       = AW'(COLS);
  localparam logic [CW-1:0]  COLS_C       = CW'(COLS);
  localparam logic [CW-1:0]  CELLS_C      = CW'(CELLS);
  localparam logic [CW-1:0]  COPY_END     = CW'(CELLS - COLS);
  localparam logic [CW-1:0]  CLEAR_END    = CW'(CELLS - 1);
  localparam logic [RW:0]    ROWS_R       = (RW + 1)'(ROWS);
  localparam logic [RW-1:0]  LAST_ROW     = RW'(ROWS - 1);
  localparam logic [CLW-1:0] LAST_COL     = CLW'(COLS - 1);

  // sequencer and request registers
  state_t         state_r, state_nxt;
  logic [1:0]     req_func_r, req_func_nxt;
  logic [7:0]     req_chr_r, req_chr_nxt;
  logic [7:0]     req_attr_r, req_attr_nxt;
  logic           req_out_r, req_out_nxt;
  logic           req_cur_r, req_cur_nxt;
  logic [RW-1:0]  req_row_r, req_row_nxt;
  logic [CLW-1:0] req_col_r, req_col_nxt;

  // cursor
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [CLW-1:0] cur_col_r, cur_col_nxt;
  logic [AW-1:0]  cur_lin_r, cur_lin_nxt;

  // sweep counter and pending write of the scroll copy
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           pend_r, pend_nxt;
  logic           pend_zero_r, pend_zero_nxt;
  logic [AW-1:0]  pend_addr_r, pend_addr_nxt;

  // held result while the output register is full
  logic           res_status_r, res_status_nxt;
  logic [7:0]     res_rch_r, res_rch_nxt;
  logic [7:0]     res_rat_r, res_rat_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [7:0]       out_rch_r, out_rch_nxt;
  logic [7:0]       out_rat_r, out_rat_nxt;

  // memory ports
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  // datapath helpers
  logic           in_beat, out_free;
  logic           col_past, row_past;
  logic [RW-1:0]  erow;
  logic [CLW-1:0] ecol;
  logic [AW-1:0]  lin;
  logic [RW:0]    row_inc;
  logic           is_nl, is_bs;
  logic [CW-1:0]  sweep_rd;
  logic           sweep_issue, sweep_copy;

  // result hand-off
  logic           fin;
  logic           fin_status;
  logic [7:0]     fin_rch, fin_rat;
  logic [AW-1:0]  fin_lin;

  tccw_cell_ram #(
    .DEPTH(CELLS),
    .AW   (AW),
    .DW   (CELL_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // coordinate checks on the incoming beat
  assign col_past = !in_col[7] && (in_col[6:0] >= 7'(COLS));
  assign row_past = !in_row[6] && (in_row[5:0] >= 6'(ROWS));

  // effective cell of the request and its linear index
  assign erow    = req_cur_r ? cur_row_r : req_row_r;
  assign ecol    = req_cur_r ? cur_col_r : req_col_r;
  assign lin     = AW'(AW'(erow) * COLS_A) + AW'(ecol);
  assign row_inc = (RW + 1)'(erow) + (RW + 1)'(1);
  assign is_nl   = (req_chr_r == CHR_NL);
  assign is_bs   = !is_nl && (req_chr_r == cfg.backspace_code);

  // scroll sweep read-address adder and range checks
  assign sweep_rd    = idx_r + COLS_C;
  assign sweep_issue = (idx_r < CELLS_C);
  assign sweep_copy  = (idx_r < COPY_END);

  // next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    req_func_nxt   = req_func_r;
    req_chr_nxt    = req_chr_r;
    req_attr_nxt   = req_attr_r;
    req_out_nxt    = req_out_r;
    req_cur_nxt    = req_cur_r;
    req_row_nxt    = req_row_r;
    req_col_nxt    = req_col_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    cur_lin_nxt    = cur_lin_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pend_zero_nxt  = pend_zero_r;
    pend_addr_nxt  = pend_addr_r;
    res_status_nxt = res_status_r;
    res_rch_nxt    = res_rch_r;
    res_rat_nxt    = res_rat_r;
    mem_we         = 1'b0;
    mem_waddr      = lin;
    mem_wdata      = {req_attr_r, req_chr_r};
    mem_re         = 1'b0;
    mem_raddr      = lin;
    fin            = 1'b0;
    fin_status     = 1'b0;
    fin_rch        = '0;
    fin_rat        = '0;
    fin_lin        = cur_lin_r;

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          req_func_nxt = in_func;
          req_chr_nxt  = in_chr;
          req_attr_nxt = (in_attr == 8'd0) ? cfg.default_attr : in_attr;
          req_out_nxt  = col_past || row_past;
          req_cur_nxt  = in_col[7] || in_row[6];
          req_row_nxt  = in_row[RW-1:0];
          req_col_nxt  = in_col[CLW-1:0];
          state_nxt    = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (req_func_r)
          FUNC_PUT: begin
            if (req_out_r) begin
              // error mark in the last cell, cursor stays
              mem_we     = 1'b1;
              mem_waddr  = LAST_CELL;
              mem_wdata  = {cfg.error_attr, CHR_ERR};
              fin        = 1'b1;
              fin_status = 1'b1;
            end else if (is_bs) begin
              mem_we      = 1'b1;
              mem_wdata   = {req_attr_r, CHR_BLANK};
              cur_row_nxt = erow;
              cur_col_nxt = ecol;
              cur_lin_nxt = lin;
              fin         = 1'b1;
              fin_lin     = lin;
            end else begin
              mem_we = !is_nl;
              if (is_nl || ecol == LAST_COL) begin
                if (row_inc == ROWS_R) begin
                  // past the last row: scroll the screen up one row
                  cur_row_nxt = LAST_ROW;
                  cur_col_nxt = '0;
                  cur_lin_nxt = LAST_ROW_LIN;
                  idx_nxt     = '0;
                  state_nxt   = ST_SCROLL;
                end else begin
                  cur_row_nxt = row_inc[RW-1:0];
                  cur_col_nxt = '0;
                  cur_lin_nxt = lin - AW'(ecol) + COLS_A;
                  fin         = 1'b1;
                  fin_lin     = cur_lin_nxt;
                end
              end else begin
                cur_row_nxt = erow;
                cur_col_nxt = ecol + CLW'(1);
                cur_lin_nxt = lin + AW'(1);
                fin         = 1'b1;
                fin_lin     = cur_lin_nxt;
              end
            end
          end
          FUNC_READ: begin
            if (req_out_r) begin
              fin        = 1'b1;
              fin_status = 1'b1;
            end else begin
              mem_re    = 1'b1;
              state_nxt = ST_RDWAIT;
            end
          end
          FUNC_CLEAR: begin
            cur_row_nxt = '0;
            cur_col_nxt = '0;
            cur_lin_nxt = '0;
            idx_nxt     = '0;
            state_nxt   = ST_CLEAR;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      ST_RDWAIT: begin
        fin     = 1'b1;
        fin_rch = mem_rdata[7:0];
        fin_rat = mem_rdata[15:8];
      end

      // fill every cell with a blank, one cell a cycle
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = {cfg.default_attr, CHR_BLANK};
        idx_nxt   = idx_r + CW'(1);
        if (idx_r == CLEAR_END) begin
          fin = 1'b1;
        end
      end

      // copy each cell from one row below, then zero the last row
      ST_SCROLL: begin
        if (sweep_issue) begin
          mem_re        = sweep_copy;
          mem_raddr     = sweep_rd[AW-1:0];
          pend_nxt      = 1'b1;
          pend_zero_nxt = !sweep_copy;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_r + CW'(1);
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = pend_zero_r ? '0 : mem_rdata;
        end
        if (!sweep_issue && !pend_r) begin
          fin = 1'b1;
        end
      end

      ST_RESP: begin
        fin        = 1'b1;
        fin_status = res_status_r;
        fin_rch    = res_rch_r;
        fin_rat    = res_rat_r;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand the result to the output register or hold it
    if (fin) begin
      res_status_nxt = fin_status;
      res_rch_nxt    = fin_rch;
      res_rat_nxt    = fin_rat;
      state_nxt      = out_free ? ST_IDLE : ST_RESP;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_rch_nxt    = out_rch_r;
    out_rat_nxt    = out_rat_r;
    if (fin && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_pos_nxt    = POS_W'(fin_lin);
      out_rch_nxt    = fin_rch;
      out_rat_nxt    = fin_rat;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cur_lin_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_lin_r   <= cur_lin_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_func_r   <= req_func_nxt;
    req_chr_r    <= req_chr_nxt;
    req_attr_r   <= req_attr_nxt;
    req_out_r    <= req_out_nxt;
    req_cur_r    <= req_cur_nxt;
    req_row_r    <= req_row_nxt;
    req_col_r    <= req_col_nxt;
    idx_r        <= idx_nxt;
    pend_zero_r  <= pend_zero_nxt;
    pend_addr_r  <= pend_addr_nxt;
    res_status_r <= res_status_nxt;
    res_rch_r    <= res_rch_nxt;
    res_rat_r    <= res_rat_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_rch_r    <= out_rch_nxt;
    out_rat_r    <= out_rat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_position  = out_pos_r;
  assign out_read_char = out_rch_r;
  assign out_read_attr = out_rat_r;

endmodule

// ===== rtl/text_console_cell_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// text-mode screen engine: put, read and clear on a ROWS x COLS cell grid
// with cursor, newline, backspace and scroll-up
// ----------------------------------------------------------------------------
//  channel   | direction | handshake        | beat
//  in_*      | input     | in_valid/ready   | func, chr, attr, col, row
//  out_*     | output    | out_valid/ready  | status, position, read_char/attr
//  apb       | input     | psel/penable     | register write or read
//
// a put that does not scroll is accepted, then written to memory; a read is
// accepted, then issued to the registered memory read and answered; a clear
// writes one cell a cycle; a scroll copies one cell a cycle, then drains.
// no clearing pass after reset: cells are undefined until cleared or written.
// a stalled result beat is held in the output register and the next beat is
// accepted; its result then waits inside, input not ready, until it frees.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit #(
  parameter int COLS = tccw_pkg::DEF_COLS,
  parameter int ROWS = tccw_pkg::DEF_ROWS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [7:0]                  in_chr,
  input  logic [7:0]                  in_attr,
  input  logic signed [7:0]           in_col,
  input  logic signed [6:0]           in_row,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status,
  output logic [tccw_pkg::POS_W-1:0]  out_position,
  output logic [7:0]                  out_read_char,
  output logic [7:0]                  out_read_attr,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tccw_pkg::ADDR_W-1:0] paddr,
  input  logic [tccw_pkg::DATA_W-1:0] pwdata,
  output logic [tccw_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  import tccw_pkg::*;

  cfg_t cfg;

  // register bank
  tccw_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // sequencer, cursor and cell memory
  tccw_engine #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_chr       (in_chr),
    .in_attr      (in_attr),
    .in_col       (in_col),
    .in_row       (in_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_position (out_position),
    .out_read_char(out_read_char),
    .out_read_attr(out_read_attr)
  );

endmodule
